@@ sv/thp_pkg.sv @@
`default_nettype none

package thp_pkg;

   // shared multiplier: wide signed multiplicand, one multiplier bit per cycle
   localparam int MUL_A_W   = 96;
   localparam int MUL_B_W   = 32;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // restoring divider: one quotient bit per cycle, quotient capped at 2^40
   localparam int DIV_NUM_W = 80;
   localparam int DIV_DEN_W = 41;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam logic [DIV_DEN_W-1:0] DIV_CAP = DIV_DEN_W'(1) << (DIV_DEN_W - 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIXED      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM        = 3'd4;

   localparam logic [23:0] SKIP24 = 24'h800000;
   localparam logic [15:0] SKIP16 = 16'h8000;

   localparam logic signed [32:0] PRESS_T_OFS = 33'sd128000;
   localparam logic signed [32:0] HUM_T_OFS   = 33'sd76800;
   localparam logic signed [95:0] HUM_MAX     = 96'sd419430400;

   typedef struct packed {
      logic [23:0] raw_temperature;
      logic [23:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic [16:0]        humidity_q22_10;
      logic               temperature_valid;
      logic               pressure_valid;
      logic               humidity_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_D1,
      ST_T_D2,
      ST_T_T3,
      ST_P_V1SQ,
      ST_P_P6,
      ST_P_P5,
      ST_P_P3,
      ST_P_P2,
      ST_P_P1,
      ST_P_SCALE,
      ST_P_DIV,
      ST_P_ASQ,
      ST_P_P9,
      ST_P_P8,
      ST_H_H5,
      ST_H_H6,
      ST_H_H3,
      ST_H_PB,
      ST_H_H2,
      ST_H_X,
      ST_H_SSQ,
      ST_H_H1,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ sv/thp_sensor_compensation.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   thp_pkg::req_type raw readings
// rsp       out        rsp_valid/rsp_stall   thp_pkg::rsp_type compensated values
// csr       in         csr_we                csr_index, csr_wdata
//
// One item at a time: one shared shift-add multiplier and a restoring divider
// for the pressure quotient. Skipped channels cost nothing.
// Synchronous reset clears calibration and fine temperature. A finished result
// waits in the output register while the next item is taken; rsp_stall holds it.
`default_nettype none

module thp_sensor_compensation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire thp_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output thp_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [thp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [thp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int W = thp_pkg::MUL_A_W;

   thp_pkg::state_type state_ff, state_in;
   logic               issued_ff, issued_in;
   thp_pkg::req_type   req_ff, req_in;
   thp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] ft_ff, ft_in;
   logic signed [W-1:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] tc_ff, tc_in;
   logic [31:0]        press_ff, press_in;
   logic [16:0]        hum_ff, hum_in;

   logic [47:0] temp_calib_ff, temp_calib_in;
   logic [63:0] press_low_ff, press_low_in;
   logic [63:0] press_high_ff, press_high_in;
   logic [47:0] mixed_calib_ff, mixed_calib_in;
   logic [31:0] hum_calib_ff, hum_calib_in;

   logic                        mul_start, mul_done;
   logic signed [W-1:0]         mul_a, mul_prod;
   logic signed [thp_pkg::MUL_B_W-1:0] mul_b;
   logic                        div_start, div_done;
   logic [thp_pkg::DIV_NUM_W-1:0] div_num;
   logic [thp_pkg::DIV_DEN_W-1:0] div_den, div_quo;

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]         h1, h3;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   logic [19:0]         adc_t;
   logic signed [18:0]  d1;
   logic signed [17:0]  d2;
   logic signed [W-1:0] adc_p_s, hraw_s;
   logic signed [32:0]  v1_w, vh_w;
   logic signed [31:0]  fine_w;
   logic signed [35:0]  tc_w;
   logic signed [W-1:0] press_w, den_mag, hx_s;
   logic                tv, pv, hv, in_pv, in_hv, in_tv;
   thp_pkg::state_type  after_t, after_p;

   function automatic logic [16:0] hum_clamp(input logic signed [95:0] x);
      logic signed [95:0] c;
      c = x;
      if (x < 0) begin
         c = '0;
      end else if (x > thp_pkg::HUM_MAX) begin
         c = thp_pkg::HUM_MAX;
      end
      return c[28:12];
   endfunction

   assign t1 = temp_calib_ff[15:0];
   assign t2 = $signed(temp_calib_ff[31:16]);
   assign t3 = $signed(temp_calib_ff[47:32]);
   assign p1 = press_low_ff[15:0];
   assign p2 = $signed(press_low_ff[31:16]);
   assign p3 = $signed(press_low_ff[47:32]);
   assign p4 = $signed(press_low_ff[63:48]);
   assign p5 = $signed(press_high_ff[15:0]);
   assign p6 = $signed(press_high_ff[31:16]);
   assign p7 = $signed(press_high_ff[47:32]);
   assign p8 = $signed(press_high_ff[63:48]);
   assign p9 = $signed(mixed_calib_ff[15:0]);
   assign h1 = mixed_calib_ff[23:16];
   assign h2 = $signed(mixed_calib_ff[39:24]);
   assign h3 = mixed_calib_ff[47:40];
   assign h4 = $signed(hum_calib_ff[11:0]);
   assign h5 = $signed(hum_calib_ff[23:12]);
   assign h6 = $signed(hum_calib_ff[31:24]);

   assign in_tv = (req_data.raw_temperature != thp_pkg::SKIP24);
   assign in_pv = (req_data.raw_pressure != thp_pkg::SKIP24);
   assign in_hv = (req_data.raw_humidity != thp_pkg::SKIP16);
   assign tv = (req_ff.raw_temperature != thp_pkg::SKIP24);
   assign pv = (req_ff.raw_pressure != thp_pkg::SKIP24);
   assign hv = (req_ff.raw_humidity != thp_pkg::SKIP16);

   assign after_p = hv ? thp_pkg::ST_H_H5 : thp_pkg::ST_EMIT;
   assign after_t = pv ? thp_pkg::ST_P_V1SQ : after_p;

   assign adc_t   = req_ff.raw_temperature[23:4];
   assign d1      = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, t1, 1'b0});
   assign d2      = $signed({2'b00, adc_t[19:4]}) - $signed({2'b00, t1});
   assign adc_p_s = $signed(W'(req_ff.raw_pressure[23:4]));
   assign hraw_s  = $signed(W'(req_ff.raw_humidity));
   assign v1_w    = 33'(ft_ff) - thp_pkg::PRESS_T_OFS;
   assign vh_w    = 33'(ft_ff) - thp_pkg::HUM_T_OFS;
   assign fine_w  = 32'(r0_ff + (mul_prod >>> 14));
   assign tc_w    = (36'(fine_w) * 36'sd5 + 36'sd128) >>> 8;
   assign press_w = ((r0_ff + r3_ff + (mul_prod >>> 19)) >>> 8) + (W'(p7) <<< 4);
   assign den_mag = r3_ff[W-1] ? -r3_ff : r3_ff;
   assign hx_s    = mul_prod >>> 15;

   assign div_num = r0_ff[thp_pkg::DIV_NUM_W-1:0];
   assign div_den = den_mag[thp_pkg::DIV_DEN_W-1:0];

   thp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   thp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      temp_calib_in  = temp_calib_ff;
      press_low_in   = press_low_ff;
      press_high_in  = press_high_ff;
      mixed_calib_in = mixed_calib_ff;
      hum_calib_in   = hum_calib_ff;
      if (csr_we) begin
         case (csr_index)
            thp_pkg::CSR_TEMP:       temp_calib_in  = csr_wdata[47:0];
            thp_pkg::CSR_PRESS_LOW:  press_low_in   = csr_wdata;
            thp_pkg::CSR_PRESS_HIGH: press_high_in  = csr_wdata;
            thp_pkg::CSR_MIXED:      mixed_calib_in = csr_wdata[47:0];
            thp_pkg::CSR_HUM:        hum_calib_in   = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      req_in       = req_ff;
      ft_in        = ft_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      neg_in       = neg_ff;
      tc_in        = tc_ff;
      press_in     = press_ff;
      hum_in       = hum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      case (state_ff)
         thp_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               tc_in    = '0;
               press_in = '0;
               hum_in   = '0;
               if (in_tv) begin
                  state_in = thp_pkg::ST_T_D1;
               end else if (in_pv) begin
                  state_in = thp_pkg::ST_P_V1SQ;
               end else if (in_hv) begin
                  state_in = thp_pkg::ST_H_H5;
               end else begin
                  state_in = thp_pkg::ST_EMIT;
               end
            end
         end

         thp_pkg::ST_T_D1: begin
            mul_a = W'(d1);
            mul_b = 32'(t2);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r0_in = mul_prod >>> 11;
               state_in = thp_pkg::ST_T_D2;
            end
         end

         thp_pkg::ST_T_D2: begin
            mul_a = W'(d2);
            mul_b = 32'(d2);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = mul_prod >>> 12;
               state_in = thp_pkg::ST_T_T3;
            end
         end

         thp_pkg::ST_T_T3: begin
            mul_a = r1_ff;
            mul_b = 32'(t3);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               ft_in = fine_w;
               if (tc_w > 36'sd32767) begin
                  tc_in = 16'sh7FFF;
               end else if (tc_w < -36'sd32768) begin
                  tc_in = -16'sh8000;
               end else begin
                  tc_in = tc_w[15:0];
               end
               state_in = after_t;
            end
         end

         thp_pkg::ST_P_V1SQ: begin
            mul_a = W'(v1_w);
            mul_b = 32'(v1_w);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r0_in = mul_prod;
               state_in = thp_pkg::ST_P_P6;
            end
         end

         thp_pkg::ST_P_P6: begin
            mul_a = r0_ff;
            mul_b = 32'(p6);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = mul_prod;
               state_in = thp_pkg::ST_P_P5;
            end
         end

         thp_pkg::ST_P_P5: begin
            mul_a = W'(v1_w);
            mul_b = 32'(p5);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = r1_ff + (mul_prod <<< 17) + (W'(p4) <<< 35);
               state_in = thp_pkg::ST_P_P3;
            end
         end

         thp_pkg::ST_P_P3: begin
            mul_a = r0_ff;
            mul_b = 32'(p3);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r2_in = mul_prod >>> 8;
               state_in = thp_pkg::ST_P_P2;
            end
         end

         thp_pkg::ST_P_P2: begin
            mul_a = W'(v1_w);
            mul_b = 32'(p2);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r2_in = r2_ff + (mul_prod <<< 12);
               state_in = thp_pkg::ST_P_P1;
            end
         end

         thp_pkg::ST_P_P1: begin
            mul_a = r2_ff + (W'(1) <<< 47);
            mul_b = $signed({16'b0, p1});
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r3_in = mul_prod >>> 33;
               // numerator: (2^20 - adc) * 2^31 - v2
               r1_in = (($signed(W'(1048576)) - adc_p_s) <<< 31) - r1_ff;
               if ((mul_prod >>> 33) == '0) begin
                  press_in = '0;
                  state_in = after_p;
               end else begin
                  state_in = thp_pkg::ST_P_SCALE;
               end
            end
         end

         thp_pkg::ST_P_SCALE: begin
            mul_a = r1_ff[W-1] ? -r1_ff : r1_ff;
            mul_b = 32'sd3125;
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r0_in = mul_prod;
               neg_in = r1_ff[W-1] ^ r3_ff[W-1];
               state_in = thp_pkg::ST_P_DIV;
            end
         end

         thp_pkg::ST_P_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               r0_in = neg_ff ? -$signed(W'(div_quo)) : $signed(W'(div_quo));
               state_in = thp_pkg::ST_P_ASQ;
            end
         end

         thp_pkg::ST_P_ASQ: begin
            mul_a = r0_ff >>> 13;
            mul_b = 32'(r0_ff >>> 13);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r2_in = mul_prod;
               state_in = thp_pkg::ST_P_P9;
            end
         end

         thp_pkg::ST_P_P9: begin
            mul_a = r2_ff;
            mul_b = 32'(p9);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r3_in = mul_prod >>> 25;
               state_in = thp_pkg::ST_P_P8;
            end
         end

         thp_pkg::ST_P_P8: begin
            mul_a = r0_ff;
            mul_b = 32'(p8);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               if (press_w < 0) begin
                  press_in = '0;
               end else if (press_w > $signed(W'(32'hFFFF_FFFF))) begin
                  press_in = '1;
               end else begin
                  press_in = press_w[31:0];
               end
               state_in = after_p;
            end
         end

         thp_pkg::ST_H_H5: begin
            mul_a = W'(h5);
            mul_b = 32'(vh_w);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r0_in = ((hraw_s <<< 14) - (W'(h4) <<< 20) - mul_prod + $signed(W'(16384)))
                       >>> 15;
               state_in = thp_pkg::ST_H_H6;
            end
         end

         thp_pkg::ST_H_H6: begin
            mul_a = W'(vh_w);
            mul_b = 32'(h6);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = mul_prod >>> 10;
               state_in = thp_pkg::ST_H_H3;
            end
         end

         thp_pkg::ST_H_H3: begin
            mul_a = W'(vh_w);
            mul_b = $signed({24'b0, h3});
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r2_in = (mul_prod >>> 11) + $signed(W'(32768));
               state_in = thp_pkg::ST_H_PB;
            end
         end

         thp_pkg::ST_H_PB: begin
            mul_a = r1_ff;
            mul_b = 32'(r2_ff);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = (mul_prod >>> 10) + $signed(W'(2097152));
               state_in = thp_pkg::ST_H_H2;
            end
         end

         thp_pkg::ST_H_H2: begin
            mul_a = r1_ff;
            mul_b = 32'(h2);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r1_in = (mul_prod + $signed(W'(8192))) >>> 14;
               state_in = thp_pkg::ST_H_X;
            end
         end

         thp_pkg::ST_H_X: begin
            mul_a = r1_ff;
            mul_b = 32'(r0_ff);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r0_in = mul_prod;
               r1_in = hx_s;
               if (mul_prod <= 0) begin
                  hum_in = '0;
                  state_in = thp_pkg::ST_EMIT;
               end else if (h1 == '0) begin
                  hum_in = hum_clamp(mul_prod);
                  state_in = thp_pkg::ST_EMIT;
               end else if (hx_s >= (W'(1) <<< 31)) begin
                  // correction term would exceed x
                  hum_in = '0;
                  state_in = thp_pkg::ST_EMIT;
               end else begin
                  state_in = thp_pkg::ST_H_SSQ;
               end
            end
         end

         thp_pkg::ST_H_SSQ: begin
            mul_a = r1_ff;
            mul_b = 32'(r1_ff);
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               r2_in = mul_prod >>> 7;
               state_in = thp_pkg::ST_H_H1;
            end
         end

         thp_pkg::ST_H_H1: begin
            mul_a = r2_ff;
            mul_b = $signed({24'b0, h1});
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               hum_in = hum_clamp(r0_ff - (mul_prod >>> 4));
               state_in = thp_pkg::ST_EMIT;
            end
         end

         thp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.temperature_centi = tc_ff;
               rsp_in.pressure_q24_8    = press_ff;
               rsp_in.humidity_q22_10   = hum_ff;
               rsp_in.temperature_valid = tv;
               rsp_in.pressure_valid    = pv;
               rsp_in.humidity_valid    = hv;
               rsp_valid_in = 1'b1;
               state_in = thp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = thp_pkg::ST_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= thp_pkg::ST_IDLE;
         issued_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ft_ff          <= '0;
         temp_calib_ff  <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         mixed_calib_ff <= '0;
         hum_calib_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         issued_ff      <= issued_in;
         rsp_valid_ff   <= rsp_valid_in;
         ft_ff          <= ft_in;
         temp_calib_ff  <= temp_calib_in;
         press_low_ff   <= press_low_in;
         press_high_ff  <= press_high_in;
         mixed_calib_ff <= mixed_calib_in;
         hum_calib_ff   <= hum_calib_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      r3_ff    <= r3_in;
      neg_ff   <= neg_in;
      tc_ff    <= tc_in;
      press_ff <= press_in;
      hum_ff   <= hum_in;
   end

   assign req_stall = (state_ff != thp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a unit finishes only for an operation that this sequencer issued
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> issued_ff)
      else $error("arithmetic unit finished without an issued operation");

   a_skip_press_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pressure_valid || rsp_data.pressure_q24_8 == '0))
      else $error("skipped pressure carries a nonzero value");

   a_skip_hum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.humidity_valid || rsp_data.humidity_q22_10 == '0))
      else $error("skipped humidity carries a nonzero value");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.humidity_q22_10 <= 17'd102400))
      else $error("humidity above full scale");

endmodule

`default_nettype wire

@@ sv/thp_mul.sv @@
`default_nettype none

module thp_mul (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [thp_pkg::MUL_A_W-1:0]  a,
   input  wire logic signed [thp_pkg::MUL_B_W-1:0]  b,
   output logic                                     done,
   output logic signed [thp_pkg::MUL_A_W-1:0]       prod
);

   logic signed [thp_pkg::MUL_A_W-1:0] acc_ff, acc_in;
   logic signed [thp_pkg::MUL_A_W-1:0] a_ff, a_in;
   logic [thp_pkg::MUL_B_W-1:0]        b_ff, b_in;
   logic [thp_pkg::MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               last;

   assign last = (cnt_ff == thp_pkg::MUL_CNT_W'(thp_pkg::MUL_B_W - 1));

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // top multiplier bit carries negative weight
         if (b_ff[0]) begin
            acc_in = last ? acc_ff - a_ff : acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

@@ sv/thp_div.sv @@
`default_nettype none

module thp_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [thp_pkg::DIV_NUM_W-1:0]  num,
   input  wire logic [thp_pkg::DIV_DEN_W-1:0]  den,
   output logic                                done,
   output logic [thp_pkg::DIV_DEN_W-1:0]       quo
);

   logic [thp_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [thp_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [thp_pkg::DIV_DEN_W-1:0] quo_ff, quo_in;
   logic [thp_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [thp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          big_ff, big_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [thp_pkg::DIV_DEN_W:0]   trial;
   logic [thp_pkg::DIV_DEN_W:0]   diff;
   logic                          fits;
   logic                          last;

   assign trial = {rem_ff, num_ff[thp_pkg::DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});
   assign last  = (cnt_ff == thp_pkg::DIV_CNT_W'(thp_pkg::DIV_NUM_W - 1));

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      big_in  = big_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         quo_in  = '0;
         num_in  = num;
         cnt_in  = '0;
         big_in  = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[thp_pkg::DIV_DEN_W-1:0] : trial[thp_pkg::DIV_DEN_W-1:0];
         // any bit shifted out of the quotient means it is past the cap
         big_in = big_ff | quo_ff[thp_pkg::DIV_DEN_W-1];
         quo_in = {quo_ff[thp_pkg::DIV_DEN_W-2:0], fits};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      big_ff <= big_in;
   end

   assign done = done_ff;
   assign quo  = (big_ff || quo_ff > thp_pkg::DIV_CAP) ? thp_pkg::DIV_CAP : quo_ff;

endmodule

`default_nettype wire
